// ===== src/csvtok_pkg.sv =====
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared constants and types of the CSV stream tokenizer: character codes,
// token kinds and the token bundle that one text byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

package csvtok_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam int unsigned MaxTokens = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    token_t [MaxTokens-1:0]     tok;
  } bundle_t;

endpackage : csvtok_pkg

`default_nettype wire

// ===== src/csvtok_ifs.sv =====
// ----------------------------------------------------------------------------
// csvtok_ifs
// Valid/ready stream interfaces for the text byte input and the token output.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvtok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface : csvtok_in_if

interface csvtok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] content_byte;
  logic       run_last;

  modport source (output valid, output token_kind, output content_byte,
                  output run_last, input ready);
  modport sink   (input valid, input token_kind, input content_byte,
                  input run_last, output ready);
endinterface : csvtok_out_if

`default_nettype wire

// ===== src/csvtok_step.sv =====
// ----------------------------------------------------------------------------
// csvtok_step
// Parser state and the per-byte decision logic. Builds the bundle of tokens
// that the presented byte produces and updates the state on a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_step
  import csvtok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       text_last,
  output bundle_t         bundle
);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QPEND,
    MODE_CRPEND
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  content_r, content_nxt;

  always_comb begin
    token_t [MaxTokens-1:0] tok;
    logic [1:0]             n;
    logic                   do_plain;
    tok      = '0;
    n        = 2'd0;
    do_plain = 1'b0;
    mode_nxt    = mode_r;
    content_nxt = content_r;

    case (mode_r)
      MODE_QUOTED: begin
        if (text_byte == CH_QUOTE) begin
          mode_nxt = text_last ? MODE_PLAIN : MODE_QPEND;
        end else begin
          tok[n] = '{kind: KIND_BYTE, data: text_byte, last: 1'b0};
          n = n + 2'd1;
        end
      end
      MODE_QPEND: begin
        if (text_byte == CH_QUOTE) begin
          tok[n] = '{kind: KIND_BYTE, data: CH_QUOTE, last: 1'b0};
          n = n + 2'd1;
          mode_nxt = MODE_QUOTED;
        end else begin
          mode_nxt = MODE_PLAIN;
          do_plain = 1'b1;
        end
      end
      MODE_CRPEND: begin
        mode_nxt = MODE_PLAIN;
        do_plain = (text_byte != CH_LF);
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (text_byte == CH_QUOTE) begin
        mode_nxt    = MODE_QUOTED;
        content_nxt = 1'b1;
      end else if (text_byte == CH_COMMA) begin
        tok[n] = '{kind: KIND_FIELD, data: 8'd0, last: 1'b0};
        n = n + 2'd1;
        content_nxt = 1'b1;
      end else if (text_byte == CH_CR || text_byte == CH_LF) begin
        if (content_nxt) begin
          tok[n] = '{kind: KIND_ROW, data: 8'd0, last: 1'b0};
          n = n + 2'd1;
        end
        content_nxt = 1'b0;
        mode_nxt = (text_byte == CH_CR && !text_last) ? MODE_CRPEND : MODE_PLAIN;
      end else begin
        tok[n] = '{kind: KIND_BYTE, data: text_byte, last: 1'b0};
        n = n + 2'd1;
        content_nxt = 1'b1;
      end
    end

    if (text_last) begin
      if (content_nxt) begin
        tok[n] = '{kind: KIND_ROW, data: 8'd0, last: 1'b0};
        n = n + 2'd1;
      end
      tok[n] = '{kind: KIND_END, data: 8'd0, last: 1'b0};
      n = n + 2'd1;
      mode_nxt    = MODE_PLAIN;
      content_nxt = 1'b0;
    end

    if (n != 2'd0) begin
      tok[n - 2'd1].last = 1'b1;
    end

    bundle.cnt = n;
    bundle.tok = tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      content_r <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      content_r <= content_nxt;
    end
  end

endmodule : csvtok_step

`default_nettype wire

// ===== src/csvtok_serializer.sv =====
// ----------------------------------------------------------------------------
// csvtok_serializer
// Holds the token bundle of one byte and hands its tokens one per cycle to
// the output register while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_serializer
  import csvtok_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire bundle_t  bundle,
  output logic          ready,
  output logic          out_valid,
  output token_t        out_tok,
  input  wire logic     out_ready
);

  logic [1:0]             cnt_r, cnt_nxt;
  token_t [MaxTokens-1:0] tok_r, tok_nxt;
  logic                   out_valid_r, out_valid_nxt;
  token_t                 out_tok_r, out_tok_nxt;
  logic                   pop;

  assign pop   = (cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign ready = (cnt_r == 2'd0) || (pop && cnt_r == 2'd1);

  always_comb begin
    cnt_nxt       = cnt_r;
    tok_nxt       = tok_r;
    out_valid_nxt = out_valid_r;
    out_tok_nxt   = out_tok_r;
    if (pop) begin
      for (int i = 0; i < MaxTokens - 1; i++) begin
        tok_nxt[i] = tok_r[i+1];
      end
      cnt_nxt       = cnt_r - 2'd1;
      out_valid_nxt = 1'b1;
      out_tok_nxt   = tok_r[0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      cnt_nxt = bundle.cnt;
      tok_nxt = bundle.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r     <= tok_nxt;
    out_tok_r <= out_tok_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_tok_r;

endmodule : csvtok_serializer

`default_nettype wire

// ===== src/csv_stream_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_unit
// CSV text tokenizer: bytes in, content/field-end/row-end/end-of-text tokens out.
// ----------------------------------------------------------------------------
// The block takes one byte of CSV text per transfer and delivers the tokens
// that byte produces, in order, one token per output transfer. A byte that
// produces at most one token is taken every cycle unless the output stalls;
// a byte that produces k tokens (at most three, on the final byte of a text)
// holds off the next byte until its last token enters the single token
// output register. Bytes with no token hold nothing off. Tokens pass through
// the held bundle, then the output register. The byte flagged as last closes
// the text and resets the parser state, so the next byte starts a new text.
`default_nettype none

module csv_stream_tokenizer_unit
  import csvtok_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  csvtok_in_if.sink    in_ch,
  csvtok_out_if.source out_ch
);

  bundle_t bundle;
  token_t  out_tok;
  logic    ser_ready;
  logic    accept;

  assign in_ch.ready = ser_ready;
  assign accept      = in_ch.valid && ser_ready;

  csvtok_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_ch.text_byte),
    .text_last (in_ch.text_last),
    .bundle    (bundle)
  );

  csvtok_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .bundle    (bundle),
    .ready     (ser_ready),
    .out_valid (out_ch.valid),
    .out_tok   (out_tok),
    .out_ready (out_ch.ready)
  );

  assign out_ch.token_kind   = out_tok.kind;
  assign out_ch.content_byte = out_tok.data;
  assign out_ch.run_last     = out_tok.last;

endmodule : csv_stream_tokenizer_unit

`default_nettype wire

// ===== src/csvtok_checker.sv =====
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks of the CSV stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_checker
  import csvtok_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] token_kind,
  input wire logic [7:0] content_byte,
  input wire logic       run_last
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind)
      && $stable(content_byte) && $stable(run_last))
    else $error("Stalled output transfer changed.");

  a_marker_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind != KIND_BYTE |-> content_byte == 8'd0)
    else $error("Marker token carries a data byte.");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind == KIND_END |-> run_last)
    else $error("End-of-text token is not the last of its byte.");

endmodule : csvtok_checker

bind csv_stream_tokenizer_unit csvtok_checker u_csvtok_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .content_byte (out_ch.content_byte),
  .run_last     (out_ch.run_last)
);

`default_nettype wire
